// ===== hw/rtl/cht_pkg.sv =====
// cht_pkg: shared constants, payload structs, entry layout and control codes
// for the chained hash table. No dependencies.
package cht_pkg;

	localparam int MAX_BUCKETS = 16384;
	localparam int NODE_POOL   = 4096;
	localparam int BKT_W       = $clog2(MAX_BUCKETS);
	localparam int NODE_W      = $clog2(NODE_POOL);
	localparam int LINK_W      = NODE_W + 1;
	localparam int CNT_W       = 15;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 64;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODE_POOL);
	localparam logic [CNT_W-1:0]  BUCKETS_RST = CNT_W'(1543);

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [KEY_W-1:0] key;
		logic [VAL_W-1:0]        value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] found_value;
		logic             status;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [LINK_W-1:0] link;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_HEAD_CAP,
		OP_INS_HEAD,
		OP_INS_NODE,
		OP_FULL,
		OP_SRCH_HEAD_HIT,
		OP_SRCH_HIT,
		OP_SKIP,
		OP_DEL_PULL,
		OP_DEL_CLR,
		OP_DEL_UNLINK,
		OP_DEL_SKIP,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic div_done;
		logic clr_last;
		logic head_empty;
		logic head_match;
		logic cur_null;
		logic node_match;
		logic next_null;
		logic pool_empty;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_HEAD_RD,
		ST_HEAD_CAP,
		ST_DECIDE,
		ST_POP_RD,
		ST_POP,
		ST_PULL_RD,
		ST_PULL,
		ST_NODE_RD,
		ST_NODE_CHK,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/cht_mod.sv =====
// cht_mod: bucket index unit, signed key modulo clamped bucket count.
// Restoring remainder, four bits a cycle. Depends on cht_pkg.
module cht_mod (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [cht_pkg::KEY_W-1:0] key,
	input  logic [cht_pkg::CNT_W-1:0]       count,
	output logic                            done,
	output logic [cht_pkg::BKT_W-1:0]       bucket
);
	localparam int STEPS = cht_pkg::KEY_W / 4;
	localparam int SC_W  = $clog2(STEPS);

	logic [cht_pkg::CNT_W-1:0] n_q;
	logic [cht_pkg::KEY_W-1:0] mag_q;
	logic [cht_pkg::CNT_W:0]   rem_q;
	logic                      neg_q;
	logic [SC_W-1:0]           cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [cht_pkg::BKT_W-1:0] bucket_q;

	logic [cht_pkg::CNT_W-1:0] n_clamp;
	logic [cht_pkg::CNT_W:0]   rem_nx;
	logic [cht_pkg::KEY_W-1:0] mag_nx;
	logic [cht_pkg::CNT_W:0]   fix;

	always_comb begin
		if (count == '0)
			n_clamp = cht_pkg::CNT_W'(1);
		else if (count > cht_pkg::CNT_W'(cht_pkg::MAX_BUCKETS))
			n_clamp = cht_pkg::CNT_W'(cht_pkg::MAX_BUCKETS);
		else
			n_clamp = count;
	end

	always_comb begin
		rem_nx = rem_q;
		mag_nx = mag_q;
		for (int i = 0; i < 4; i++) begin
			rem_nx = {rem_nx[cht_pkg::CNT_W-1:0], mag_nx[cht_pkg::KEY_W-1]};
			mag_nx = {mag_nx[cht_pkg::KEY_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, n_q})
				rem_nx = rem_nx - {1'b0, n_q};
		end
		fix = (neg_q && rem_nx != '0) ? ({1'b0, n_q} - rem_nx) : rem_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + SC_W'(1);
				if (cnt_q == SC_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n_clamp;
			neg_q <= key[cht_pkg::KEY_W-1];
			mag_q <= key[cht_pkg::KEY_W-1] ? (cht_pkg::KEY_W'(0) - key) : key;
			rem_q <= '0;
		end else if (run_q) begin
			mag_q <= mag_nx;
			rem_q <= rem_nx;
			if (cnt_q == SC_W'(STEPS - 1))
				bucket_q <= fix[cht_pkg::BKT_W-1:0];
		end
	end

	assign done   = done_q;
	assign bucket = bucket_q;

endmodule

// ===== hw/rtl/cht_dp.sv =====
// cht_dp: datapath; head, node and free-stack memories, walk registers,
// pool counters, config register and result register. Uses cht_pkg, cht_mod.
module cht_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cht_pkg::op_t              op,
	input  cht_pkg::req_t             req,
	input  logic                      cfg_we,
	input  logic [cht_pkg::CNT_W-1:0] cfg_wdata,
	output cht_pkg::dp_status_t       stat,
	output logic                      done,
	output cht_pkg::rsp_t             rsp
);
	localparam int NW = cht_pkg::NODE_W;
	localparam int LW = cht_pkg::LINK_W;
	localparam int BW = cht_pkg::BKT_W;

	cht_pkg::entry_t     head_mem  [cht_pkg::MAX_BUCKETS];
	cht_pkg::entry_t     node_mem  [cht_pkg::NODE_POOL];
	logic [NW-1:0]       stack_mem [cht_pkg::NODE_POOL];

	logic [cht_pkg::CNT_W-1:0] buckets_q;
	logic [cht_pkg::KEY_W-1:0] key_q;
	logic [cht_pkg::VAL_W-1:0] val_q;
	cht_pkg::entry_t           head_rd_q, head_q, nd_q, prev_word_q;
	logic [NW-1:0]             st_q;
	logic [LW-1:0]             cur_q, prev_q;
	logic [LW-1:0]             fc_q, lw_q;
	logic [BW-1:0]             clr_q;
	logic [cht_pkg::VAL_W-1:0] found_q;
	logic                      status_q;
	logic                      done_q;
	cht_pkg::rsp_t             rsp_q;

	logic          div_done;
	logic [BW-1:0] bucket;

	logic            hw_en, nw_en, sw_en;
	logic [BW-1:0]   hw_addr;
	cht_pkg::entry_t hw_data, nw_data;
	logic [NW-1:0]   nw_addr;
	logic [NW-1:0]   pop_pos, pop_idx;
	logic            push_ok;

	cht_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (op == cht_pkg::OP_LOAD),
		.key    (req.key),
		.count  (buckets_q),
		.done   (div_done),
		.bucket (bucket)
	);

	// positions below the low-water mark were never overwritten: they hold their own index
	assign pop_pos = NW'(fc_q - LW'(1));
	assign pop_idx = ({1'b0, pop_pos} < lw_q) ? pop_pos : st_q;
	assign push_ok = fc_q < LW'(cht_pkg::NODE_POOL);

	always_comb begin
		hw_en   = 1'b0;
		hw_addr = bucket;
		hw_data = head_q;
		nw_en   = 1'b0;
		nw_addr = pop_idx;
		nw_data = nd_q;
		sw_en   = 1'b0;
		unique case (op)
			cht_pkg::OP_CLEAR: begin
				hw_en   = 1'b1;
				hw_addr = clr_q;
				hw_data = '{key: '0, value: '0, link: cht_pkg::NULL_LINK};
			end
			cht_pkg::OP_INS_HEAD: begin
				hw_en   = 1'b1;
				hw_data = '{key: key_q, value: val_q, link: head_q.link};
			end
			cht_pkg::OP_INS_NODE: begin
				hw_en   = 1'b1;
				hw_data = '{key: head_q.key, value: head_q.value, link: {1'b0, pop_idx}};
				nw_en   = 1'b1;
				nw_data = '{key: key_q, value: val_q, link: head_q.link};
			end
			cht_pkg::OP_DEL_PULL: begin
				hw_en   = 1'b1;
				hw_data = nd_q;
				sw_en   = push_ok;
			end
			cht_pkg::OP_DEL_CLR: begin
				hw_en   = 1'b1;
				hw_data = '{key: '0, value: '0, link: head_q.link};
			end
			cht_pkg::OP_DEL_UNLINK: begin
				sw_en = push_ok;
				if (prev_q[NW]) begin
					hw_en   = 1'b1;
					hw_data = '{key: head_q.key, value: head_q.value, link: nd_q.link};
				end else begin
					nw_en   = 1'b1;
					nw_addr = prev_q[NW-1:0];
					nw_data = '{key: prev_word_q.key, value: prev_word_q.value,
						link: nd_q.link};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hw_en)
			head_mem[hw_addr] <= hw_data;
		head_rd_q <= head_mem[bucket];
	end

	always_ff @(posedge clk) begin
		if (nw_en)
			node_mem[nw_addr] <= nw_data;
		nd_q <= node_mem[cur_q[NW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sw_en)
			stack_mem[fc_q[NW-1:0]] <= cur_q[NW-1:0];
		st_q <= stack_mem[pop_pos];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buckets_q <= cht_pkg::BUCKETS_RST;
			fc_q      <= LW'(cht_pkg::NODE_POOL);
			lw_q      <= LW'(cht_pkg::NODE_POOL);
			clr_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we)
				buckets_q <= cfg_wdata;
			if (op == cht_pkg::OP_CLEAR)
				clr_q <= clr_q + BW'(1);
			if (op == cht_pkg::OP_INS_NODE) begin
				fc_q <= fc_q - LW'(1);
				if ({1'b0, pop_pos} < lw_q)
					lw_q <= {1'b0, pop_pos};
			end else if (sw_en) begin
				fc_q <= fc_q + LW'(1);
			end
			done_q <= (op == cht_pkg::OP_DONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			cht_pkg::OP_LOAD: begin
				key_q    <= req.key;
				val_q    <= req.value;
				found_q  <= '0;
				status_q <= 1'b0;
			end
			cht_pkg::OP_HEAD_CAP: begin
				head_q <= head_rd_q;
				cur_q  <= head_rd_q.link;
				prev_q <= cht_pkg::NULL_LINK;
			end
			cht_pkg::OP_FULL:          status_q <= 1'b1;
			cht_pkg::OP_SRCH_HEAD_HIT: found_q  <= head_q.value;
			cht_pkg::OP_SRCH_HIT:      found_q  <= nd_q.value;
			cht_pkg::OP_SKIP, cht_pkg::OP_DEL_UNLINK: cur_q <= nd_q.link;
			cht_pkg::OP_DEL_SKIP: begin
				prev_q      <= cur_q;
				prev_word_q <= nd_q;
				cur_q       <= nd_q.link;
			end
			cht_pkg::OP_DONE: rsp_q <= '{found_value: found_q, status: status_q};
			default: begin
			end
		endcase
	end

	assign stat.div_done   = div_done;
	assign stat.clr_last   = (clr_q == BW'(cht_pkg::MAX_BUCKETS - 1));
	assign stat.head_empty = (head_q.value == '0);
	assign stat.head_match = (head_q.key == key_q);
	assign stat.cur_null   = cur_q[NW];
	assign stat.node_match = (nd_q.key == key_q);
	assign stat.next_null  = nd_q.link[NW];
	assign stat.pool_empty = (fc_q == '0);

	assign done = done_q;
	assign rsp  = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= LW'(cht_pkg::NODE_POOL))
		else $error("free count above pool size");
	assert property (@(posedge clk) disable iff (!arst_n)
		lw_q <= fc_q)
		else $error("low-water mark above free count");
	assert property (@(posedge clk) disable iff (!arst_n)
		op == cht_pkg::OP_INS_NODE |-> fc_q != '0)
		else $error("pop from empty pool");

endmodule

// ===== hw/rtl/cht_ctrl.sv =====
// cht_ctrl: operation sequencer; clearing pass, modulo wait, head access,
// insert, search and delete chain walks. Depends on cht_pkg.
module cht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          mode,
	input  cht_pkg::dp_status_t stat,
	output cht_pkg::op_t        op,
	output logic                busy
);
	cht_pkg::state_t state_q, state_nx;
	cht_pkg::mode_t  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::ST_CLEAR;
			mode_q  <= cht_pkg::MODE_NOP;
		end else begin
			state_q <= state_nx;
			if (state_q == cht_pkg::ST_IDLE && start)
				mode_q <= cht_pkg::mode_t'(mode);
		end
	end

	always_comb begin
		state_nx = state_q;
		op       = cht_pkg::OP_NONE;
		unique case (state_q)
			cht_pkg::ST_CLEAR: begin
				op = cht_pkg::OP_CLEAR;
				if (stat.clr_last)
					state_nx = cht_pkg::ST_IDLE;
			end
			cht_pkg::ST_IDLE: begin
				if (start) begin
					op       = cht_pkg::OP_LOAD;
					state_nx = cht_pkg::ST_DIV;
				end
			end
			cht_pkg::ST_DIV: if (stat.div_done) state_nx = cht_pkg::ST_HEAD_RD;
			cht_pkg::ST_HEAD_RD: state_nx = cht_pkg::ST_HEAD_CAP;
			cht_pkg::ST_HEAD_CAP: begin
				op       = cht_pkg::OP_HEAD_CAP;
				state_nx = cht_pkg::ST_DECIDE;
			end
			cht_pkg::ST_DECIDE: begin
				state_nx = cht_pkg::ST_DONE;
				unique case (mode_q)
					cht_pkg::MODE_INSERT: begin
						if (stat.head_empty)
							op = cht_pkg::OP_INS_HEAD;
						else if (stat.pool_empty)
							op = cht_pkg::OP_FULL;
						else
							state_nx = cht_pkg::ST_POP_RD;
					end
					cht_pkg::MODE_SEARCH: begin
						if (stat.head_match)
							op = cht_pkg::OP_SRCH_HEAD_HIT;
						else if (!stat.cur_null)
							state_nx = cht_pkg::ST_NODE_RD;
					end
					cht_pkg::MODE_DELETE: begin
						if (!stat.head_empty) begin
							if (stat.head_match) begin
								if (stat.cur_null)
									op = cht_pkg::OP_DEL_CLR;
								else
									state_nx = cht_pkg::ST_PULL_RD;
							end else if (!stat.cur_null) begin
								state_nx = cht_pkg::ST_NODE_RD;
							end
						end
					end
					default: begin
					end
				endcase
			end
			cht_pkg::ST_POP_RD: state_nx = cht_pkg::ST_POP;
			cht_pkg::ST_POP: begin
				op       = cht_pkg::OP_INS_NODE;
				state_nx = cht_pkg::ST_DONE;
			end
			cht_pkg::ST_PULL_RD: state_nx = cht_pkg::ST_PULL;
			cht_pkg::ST_PULL: begin
				op       = cht_pkg::OP_DEL_PULL;
				state_nx = cht_pkg::ST_DONE;
			end
			cht_pkg::ST_NODE_RD: state_nx = cht_pkg::ST_NODE_CHK;
			cht_pkg::ST_NODE_CHK: begin
				state_nx = stat.next_null ? cht_pkg::ST_DONE : cht_pkg::ST_NODE_RD;
				if (mode_q == cht_pkg::MODE_SEARCH) begin
					if (stat.node_match) begin
						op       = cht_pkg::OP_SRCH_HIT;
						state_nx = cht_pkg::ST_DONE;
					end else begin
						op = cht_pkg::OP_SKIP;
					end
				end else begin
					op = stat.node_match ? cht_pkg::OP_DEL_UNLINK : cht_pkg::OP_DEL_SKIP;
				end
			end
			cht_pkg::ST_DONE: begin
				op       = cht_pkg::OP_DONE;
				state_nx = cht_pkg::ST_IDLE;
			end
			default: state_nx = cht_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != cht_pkg::ST_IDLE);

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cht_pkg::ST_IDLE && start |=> state_q == cht_pkg::ST_DIV)
		else $error("accepted transaction did not start modulo");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cht_pkg::ST_NODE_CHK |-> $past(state_q) == cht_pkg::ST_NODE_RD)
		else $error("node check without node read");

endmodule

// ===== hw/rtl/chained_hash_table.sv =====
// chained_hash_table: one operation at a time; for an insert into an empty head, done
// rises after the modulo, the head read and the decision; a chain insert or head pull
// adds a free-stack or node memory read, and search and delete add a node read and
// check per chain node visited. A new start is taken in the cycle done is high. The
// modulo unit works four remainder bits per step, and node memory reads are registered.
// After reset busy stays high while every head is cleared; done is one unstallable cycle.
module chained_hash_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  cht_pkg::req_t             req,
	output logic                      done,
	output cht_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [cht_pkg::CNT_W-1:0] cfg_wdata
);
	cht_pkg::op_t        op;
	cht_pkg::dp_status_t stat;

	// sequencer: one transaction in flight, busy covers the whole walk
	cht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (req.mode),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	// memories, pool accounting and result register
	cht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.done      (done),
		.rsp       (rsp)
	);

	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held for two cycles");
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("busy not raised after accept");

endmodule
